### design/safr_pkg.sv
// Shared types and constants for the sensor answer frame receiver.
// No dependencies; the parser, result register, core and bench import this package.
package safr_pkg;

  localparam int SYNC_LEN      = 8;
  localparam int MIN_LEN       = 11;
  localparam int FIXED_BODY    = 10;
  localparam int CMD_FIRST     = 4;
  localparam int ERR_FIRST     = 6;

  localparam logic [7:0] HUNT_LIMIT_RESET = 8'd10;
  localparam logic [7:0] MAX_LENGTH_RESET = 8'd137;

  // Configuration register indexes
  localparam logic CFG_HUNT_LIMIT = 1'b0;
  localparam logic CFG_MAX_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_LEN_HI   = 3'd1,
    PH_LEN_LO   = 3'd2,
    PH_HEAD_SUM = 3'd3,
    PH_BODY     = 3'd4
  } safr_phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HEAD_SUM = 3'd1,
    ST_LENGTH   = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_BODY_SUM = 3'd4
  } safr_status_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FINISH  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [2:0]  status;
    logic [15:0] command;
    logic [31:0] device_error;
  } safr_result_t;

  typedef struct packed {
    logic [7:0] hunt_limit;
    logic [7:0] max_length;
  } safr_cfg_t;

  // Sync header byte at a given position
  function automatic logic [7:0] sync_byte(input logic [2:0] pos);
    logic [7:0] val;
    unique case (pos)
      3'd0: val = 8'hF1;
      3'd1: val = 8'h1F;
      3'd2: val = 8'hE2;
      3'd3: val = 8'h2E;
      3'd4: val = 8'hB6;
      3'd5: val = 8'h6B;
      3'd6: val = 8'hA8;
      default: val = 8'h8A;
    endcase
    return val;
  endfunction

endpackage

### design/safr_in_if.sv
// Input channel of the frame receiver: one received byte or a read failure.
// Depends on nothing.
interface safr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

### design/safr_out_if.sv
// Result channel of the frame receiver: payload bytes and frame endings.
// Depends on nothing.
interface safr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [2:0]  status;
  logic [15:0] command;
  logic [31:0] device_error;

  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output status, output command, output device_error, input ready);
  modport sink   (input valid, input kind, input payload_byte, input payload_index,
                  input status, input command, input device_error, output ready);
endinterface

### design/safr_parser.sv
// Frame state machine: header hunt, length, checksums and body fields.
// Depends on safr_pkg; updates its state once per accepted request.
module safr_parser
  import safr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic         mode,
  input  logic [7:0]   rx_byte,
  input  safr_cfg_t    cfg,
  output logic         res_valid,
  output safr_result_t res
);

  safr_phase_t phase, phase_next;
  logic [2:0]  hdr_pos, hdr_pos_next;
  logic [7:0]  hunt_count, hunt_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  bytes_remaining, bytes_remaining_next;
  logic [7:0]  body_position, body_position_next;
  logic [15:0] command_store, command_store_next;
  logic [31:0] error_store, error_store_next;

  logic         failed;
  logic [7:0]   sum_add;
  logic [7:0]   hunt_inc;
  logic         finish;
  safr_status_t fin_status;
  logic         emit;

  assign failed   = mode;
  assign sum_add  = running_sum + rx_byte;
  assign hunt_inc = (hunt_count == 8'hFF) ? hunt_count : hunt_count + 8'd1;

  // Next state and ending decision
  always_comb begin
    phase_next           = phase;
    hdr_pos_next         = hdr_pos;
    hunt_count_next      = hunt_count;
    running_sum_next     = running_sum;
    bytes_remaining_next = bytes_remaining;
    body_position_next   = body_position;
    command_store_next   = command_store;
    error_store_next     = error_store;
    finish               = 1'b0;
    fin_status           = ST_OK;
    emit                 = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        if (!failed && rx_byte == sync_byte(hdr_pos)) begin
          running_sum_next = sum_add;
          hunt_count_next  = '0;
          hdr_pos_next     = hdr_pos + 3'd1;
          if (hdr_pos == 3'(SYNC_LEN - 1)) begin
            phase_next = PH_LEN_HI;
          end
        end else begin
          if (!failed) begin
            running_sum_next = '0;
            hdr_pos_next     = '0;
          end
          hunt_count_next = hunt_inc;
          if (hunt_inc >= cfg.hunt_limit) begin
            finish     = 1'b1;
            fin_status = ST_TIMEOUT;
          end
        end
      end
      PH_LEN_HI: begin
        if (failed) begin
          finish     = 1'b1;
          fin_status = ST_TIMEOUT;
        end else if (rx_byte != 8'd0) begin
          finish     = 1'b1;
          fin_status = ST_LENGTH;
        end else begin
          phase_next = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if (failed || rx_byte < 8'(MIN_LEN) || rx_byte > cfg.max_length) begin
          finish     = 1'b1;
          fin_status = ST_LENGTH;
        end else begin
          running_sum_next     = sum_add;
          bytes_remaining_next = rx_byte;
          phase_next           = PH_HEAD_SUM;
        end
      end
      PH_HEAD_SUM: begin
        if (failed || sum_add != 8'd0) begin
          finish     = 1'b1;
          fin_status = ST_HEAD_SUM;
        end else begin
          running_sum_next   = '0;
          body_position_next = '0;
          phase_next         = PH_BODY;
        end
      end
      PH_BODY: begin
        if (failed) begin
          finish     = 1'b1;
          fin_status = ST_TIMEOUT;
        end else if (bytes_remaining <= 8'd1) begin
          finish     = 1'b1;
          fin_status = (sum_add == 8'd0) ? ST_OK : ST_BODY_SUM;
        end else begin
          running_sum_next     = sum_add;
          bytes_remaining_next = bytes_remaining - 8'd1;
          body_position_next   = body_position + 8'd1;
          if (body_position >= 8'(FIXED_BODY)) begin
            emit = 1'b1;
          end else if (body_position >= 8'(ERR_FIRST)) begin
            error_store_next = {error_store[23:0], rx_byte};
          end else if (body_position >= 8'(CMD_FIRST)) begin
            command_store_next = {command_store[7:0], rx_byte};
          end
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
    // Drop the whole frame after an ending or an unknown phase
    if (finish || phase_next == PH_HUNT && phase != PH_HUNT) begin
      phase_next           = PH_HUNT;
      hdr_pos_next         = '0;
      hunt_count_next      = '0;
      running_sum_next     = '0;
      bytes_remaining_next = '0;
      body_position_next   = '0;
      command_store_next   = '0;
      error_store_next     = '0;
    end
  end

  // Result for this request
  always_comb begin
    res_valid         = step && (finish || emit);
    res.kind          = finish ? KIND_FINISH : KIND_PAYLOAD;
    res.payload_byte  = finish ? 8'd0 : rx_byte;
    res.payload_index = finish ? 8'd0 : body_position - 8'(FIXED_BODY);
    res.status        = finish ? fin_status : ST_OK;
    res.command       = finish ? command_store : 16'd0;
    res.device_error  = finish ? error_store : 32'd0;
  end

  // Advance the frame state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      hdr_pos         <= '0;
      hunt_count      <= '0;
      running_sum     <= '0;
      bytes_remaining <= '0;
      body_position   <= '0;
      command_store   <= '0;
      error_store     <= '0;
    end else if (step) begin
      phase           <= phase_next;
      hdr_pos         <= hdr_pos_next;
      hunt_count      <= hunt_count_next;
      running_sum     <= running_sum_next;
      bytes_remaining <= bytes_remaining_next;
      body_position   <= body_position_next;
      command_store   <= command_store_next;
      error_store     <= error_store_next;
    end
  end

endmodule

### design/safr_out_reg.sv
// Result register between the frame state machine and the result channel.
// Depends on safr_pkg and safr_out_if.
module safr_out_reg
  import safr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  safr_result_t      res,
  output logic              free,
  safr_out_if.source        out_ch
);

  logic         full;
  safr_result_t held;

  // Accept a new result when empty or when the held one leaves this cycle
  assign free = !full || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (free) begin
      full <= load;
    end
  end

  // Hold payload until taken
  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= res;
    end
  end

  assign out_ch.valid         = full;
  assign out_ch.kind          = held.kind;
  assign out_ch.payload_byte  = held.payload_byte;
  assign out_ch.payload_index = held.payload_index;
  assign out_ch.status        = held.status;
  assign out_ch.command       = held.command;
  assign out_ch.device_error  = held.device_error;

endmodule

### design/sensor_answer_frame_receiver_core.sv
// Sensor answer frame receiver: one byte or read failure per request.
// A result is registered and shown in the cycle after the request that causes it.
// Throughput: one request per cycle, as the state updates on each accepted request;
// a new request is taken whenever the result register is empty or drained.
// Reset (synchronous, rst high): frame state cleared, hunt_limit 10, max_length 137.
// Depends on safr_pkg, safr_in_if, safr_out_if, safr_parser, safr_out_reg.
module sensor_answer_frame_receiver_core
  import safr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  safr_in_if.sink    in_ch,
  safr_out_if.source out_ch
);

  safr_cfg_t    cfg;
  safr_result_t res;
  logic         res_valid;
  logic         free;
  logic         step;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hunt_limit <= HUNT_LIMIT_RESET;
      cfg.max_length <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HUNT_LIMIT: cfg.hunt_limit <= cfg_data;
        CFG_MAX_LENGTH: cfg.max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = free;
  assign step        = in_ch.valid && free;

  safr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .mode      (in_ch.mode),
    .rx_byte   (in_ch.rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  safr_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (res_valid),
    .res    (res),
    .free   (free),
    .out_ch (out_ch)
  );

endmodule

### tb/sv/tb.sv
// Self-checking bench for sensor_answer_frame_receiver_core: builds sync-header frames,
// predicts payload bytes and frame endings, and compares each result in order.
// Depends on safr_pkg, safr_in_if, safr_out_if and the core module.
module tb;
  import safr_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [63:0] SYNC_WORD = 64'hF11F_E22E_B66B_A88A;

  typedef enum int {
    FR_GOOD,
    FR_BAD_SYNC,
    FR_LEN_HI,
    FR_LEN_RANGE,
    FR_HEAD_SUM,
    FR_BODY_SUM,
    FR_FAIL,
    FR_NOISE
  } frame_kind_t;

  typedef struct packed {
    logic       fail;
    logic [7:0] value;
  } rx_item_t;

  // Sync header byte at a given position
  function automatic logic [7:0] sync_at(int pos);
    return SYNC_WORD[63 - 8 * pos -: 8];
  endfunction

  // Tracks the frame state and the results still owed by the block
  class frame_tracker;
    logic [7:0]   hunt_limit;
    logic [7:0]   max_length;
    safr_phase_t  phase;
    logic [3:0]   hdr_pos;
    logic [7:0]   hunt_count;
    logic [7:0]   run_sum;
    logic [7:0]   remaining;
    logic [7:0]   body_pos;
    logic [15:0]  cmd;
    logic [31:0]  dev_err;
    safr_result_t due_results[$];
    int           mismatches;

    function new();
      hunt_limit = HUNT_LIMIT_RESET;
      max_length = MAX_LENGTH_RESET;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase      = PH_HUNT;
      hdr_pos    = '0;
      hunt_count = '0;
      run_sum    = '0;
      remaining  = '0;
      body_pos   = '0;
      cmd        = '0;
      dev_err    = '0;
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      if (idx == CFG_HUNT_LIMIT) begin
        hunt_limit = val;
      end else begin
        max_length = val;
      end
    endfunction

    // Queue the closing result and drop back to the hunt
    function void close(safr_status_t st);
      safr_result_t r;
      r = '0;
      r.kind = KIND_FINISH;
      r.status = st;
      r.command = cmd;
      r.device_error = dev_err;
      due_results.push_back(r);
      clear_frame();
    endfunction

    // Advance the frame state by one accepted request
    function void note_request(logic fail, logic [7:0] b);
      safr_result_t r;
      case (phase)
        PH_HUNT: begin
          if (!fail && hdr_pos < SYNC_LEN && b == sync_at(hdr_pos)) begin
            run_sum += b;
            hunt_count = '0;
            hdr_pos++;
            if (hdr_pos >= SYNC_LEN) phase = PH_LEN_HI;
          end else begin
            if (!fail) begin
              run_sum = '0;
              hdr_pos = '0;
            end
            if (hunt_count != 8'hFF) hunt_count++;
            if (hunt_count >= hunt_limit) close(ST_TIMEOUT);
          end
        end
        PH_LEN_HI: begin
          if (fail) close(ST_TIMEOUT);
          else if (b != 8'h00) close(ST_LENGTH);
          else phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (fail || b < MIN_LEN || b > max_length) begin
            close(ST_LENGTH);
          end else begin
            run_sum += b;
            remaining = b;
            phase = PH_HEAD_SUM;
          end
        end
        PH_HEAD_SUM: begin
          if (fail) begin
            close(ST_HEAD_SUM);
          end else begin
            run_sum += b;
            if (run_sum != 8'h00) begin
              close(ST_HEAD_SUM);
            end else begin
              body_pos = '0;
              phase = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (fail) begin
            close(ST_TIMEOUT);
          end else begin
            run_sum += b;
            if (remaining <= 1) begin
              close(run_sum == 8'h00 ? ST_OK : ST_BODY_SUM);
            end else begin
              remaining--;
              if (body_pos >= CMD_FIRST && body_pos < ERR_FIRST) begin
                cmd = {cmd[7:0], b};
              end else if (body_pos >= ERR_FIRST && body_pos < FIXED_BODY) begin
                dev_err = {dev_err[23:0], b};
              end else if (body_pos >= FIXED_BODY) begin
                r = '0;
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                r.payload_index = body_pos - 8'(FIXED_BODY);
                due_results.push_back(r);
              end
              body_pos++;
            end
          end
        end
        default: clear_frame();
      endcase
    endfunction

    function void flag(string what, safr_result_t want, safr_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected kind=%0d byte=%02h index=%0d status=%0d cmd=%04h err=%08h",
                 what, want.kind, want.payload_byte, want.payload_index, want.status,
                 want.command, want.device_error);
        $display("  actual kind=%0d byte=%02h index=%0d status=%0d cmd=%04h err=%08h",
                 got.kind, got.payload_byte, got.payload_index, got.status,
                 got.command, got.device_error);
      end
    endfunction

    // Compare one delivered result with the oldest one owed
    function void check_result(safr_result_t got);
      safr_result_t want;
      string bad;
      if (due_results.size() == 0) begin
        flag("result with nothing outstanding", '0, got);
        return;
      end
      want = due_results.pop_front();
      bad = "";
      if (got.kind !== want.kind) bad = {bad, " kind"};
      if (got.payload_byte !== want.payload_byte) bad = {bad, " payload_byte"};
      if (got.payload_index !== want.payload_index) bad = {bad, " payload_index"};
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.command !== want.command) bad = {bad, " command"};
      if (got.device_error !== want.device_error) bad = {bad, " device_error"};
      if (bad != "") flag({"mismatch in", bad}, want, got);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  safr_in_if  in_ch();
  safr_out_if out_ch();

  sensor_answer_frame_receiver_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  frame_tracker tracker = new();
  int unsigned  cycle_count = 0;
  int           items_sent = 0;
  bit           feed_steady = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Predict on every accepted request, check every accepted result
  always @(posedge clk) begin : watch
    safr_result_t seen;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) tracker.note_request(in_ch.mode, in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        seen.kind          = out_ch.kind;
        seen.payload_byte  = out_ch.payload_byte;
        seen.payload_index = out_ch.payload_index;
        seen.status        = out_ch.status;
        seen.command       = out_ch.command;
        seen.device_error  = out_ch.device_error;
        tracker.check_result(seen);
      end
    end
  end

  // Stall the result side at random once a result is waiting
  initial begin : result_sink
    int stall;
    bit steady;
    steady = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
        repeat (stall - 1) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_item(logic fail, logic [7:0] b);
    int gap;
    if ($urandom_range(0, 15) == 0) feed_steady = !feed_steady;
    gap = feed_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= fail;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Hold the sender until every owed result has come, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Mostly short bodies, now and then the largest one allowed
  function automatic int pick_len();
    int span;
    span = int'(tracker.max_length) - MIN_LEN;
    if (span > 24) span = 24;
    if ($urandom_range(0, 15) == 0) return int'(tracker.max_length);
    return MIN_LEN + $urandom_range(0, span);
  endfunction

  function automatic int bad_len();
    if (tracker.max_length == 8'hFF || $urandom_range(0, 1) == 0)
      return $urandom_range(0, MIN_LEN - 1);
    return $urandom_range(int'(tracker.max_length) + 1, 255);
  endfunction

  // Build one frame, spoiled as the kind asks, and send it
  task automatic send_frame(frame_kind_t kind, int len);
    rx_item_t   seq[$];
    logic [7:0] sum;
    logic [7:0] v;
    int         spot;
    sum = '0;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 20))
        seq.push_back('{($urandom_range(0, 2) == 0), 8'($urandom)});
    end else begin
      for (int i = 0; i < SYNC_LEN; i++) begin
        seq.push_back('{1'b0, sync_at(i)});
        sum += sync_at(i);
      end
      if (kind == FR_BAD_SYNC) begin
        spot = $urandom_range(0, SYNC_LEN - 1);
        seq = seq[0:spot];
        seq[spot].value = sync_at(spot) ^ 8'($urandom_range(1, 255));
      end else if (kind == FR_LEN_HI) begin
        seq.push_back('{1'b0, 8'($urandom_range(1, 255))});
      end else begin
        seq.push_back('{1'b0, 8'h00});
        seq.push_back('{1'b0, 8'(len)});
        if (kind != FR_LEN_RANGE) begin
          sum += 8'(len);
          v = -sum;
          if (kind == FR_HEAD_SUM) v += 8'($urandom_range(1, 255));
          seq.push_back('{1'b0, v});
          if (kind != FR_HEAD_SUM) begin
            sum = '0;
            for (int i = 0; i < len - 1; i++) begin
              v = 8'($urandom);
              sum += v;
              seq.push_back('{1'b0, v});
            end
            v = -sum;
            if (kind == FR_BODY_SUM) v += 8'($urandom_range(1, 255));
            seq.push_back('{1'b0, v});
          end
        end
      end
      // Drop a read failure anywhere in the frame
      if (kind == FR_FAIL) begin
        spot = $urandom_range(0, seq.size() - 1);
        seq.insert(spot, '{1'b1, 8'($urandom)});
      end
    end
    foreach (seq[i]) send_item(seq[i].fail, seq[i].value);
  endtask

  // Send frames until the request count reaches the target; sweep every kind first if asked
  task automatic run_frames(int target, bit sweep);
    int          n;
    int          r;
    frame_kind_t kind;
    n = 0;
    while (items_sent < target) begin
      r = $urandom_range(0, 13);
      if (sweep && n <= FR_NOISE) kind = frame_kind_t'(n);
      else kind = (r < 7) ? FR_GOOD : frame_kind_t'(r - 6);
      send_frame(kind, (kind == FR_LEN_RANGE) ? bad_len() : pick_len());
      n++;
      if (n % 8 == 0) drain();
    end
  endtask

  initial begin : stimulus
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_HUNT_LIMIT;
    cfg_data      <= 8'h00;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Byte extremes and a failure while hunting, then the shortest frame
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'hFF);
    send_frame(FR_GOOD, MIN_LEN);
    run_frames(140, 1'b1);

    // Tightest limits
    drain();
    write_reg(CFG_HUNT_LIMIT, 8'd1);
    write_reg(CFG_MAX_LENGTH, 8'd11);
    run_frames(230, 1'b0);

    // Widest limits, with one body of the largest size
    drain();
    write_reg(CFG_HUNT_LIMIT, 8'd255);
    write_reg(CFG_MAX_LENGTH, 8'd255);
    send_frame(FR_GOOD, 255);
    run_frames(560, 1'b0);

    // Zero hunt limit behaves like one
    drain();
    write_reg(CFG_HUNT_LIMIT, 8'd0);
    write_reg(CFG_MAX_LENGTH, 8'($urandom_range(11, 255)));
    run_frames(630, 1'b0);

    drain();
    write_reg(CFG_HUNT_LIMIT, 8'($urandom_range(2, 40)));
    write_reg(CFG_MAX_LENGTH, 8'($urandom_range(11, 255)));
    run_frames(700, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (tracker.pending() != 0) $display("%0d results never arrived", tracker.pending());
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
design/safr_pkg.sv
design/safr_in_if.sv
design/safr_out_if.sv
design/safr_parser.sv
design/safr_out_reg.sv
design/sensor_answer_frame_receiver_core.sv
tb/sv/tb.sv
